// File: src/dfs_pkg.sv
package dfs_pkg;

	// fixed field widths
	localparam int VTX_W = 5;
	localparam int CMD_W = 2;
	localparam int CNT_W = 6;
	localparam int EXT_W = 7;

	localparam logic [CNT_W-1:0] CNT_RESET = 6'd32;

	// command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [VTX_W-1:0] src_vertex;
		logic [VTX_W-1:0] dst_vertex;
	} in_word_t;

	typedef struct packed {
		logic [VTX_W-1:0] path_vertex;
		logic             path_found;
		logic             last;
	} out_word_t;

	// result load request from the sequencer to the output register
	typedef struct packed {
		logic      load;
		out_word_t word;
	} out_load_t;

endpackage

// File: src/dfs_ram.sv
module dfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/dfs_out.sv
module dfs_out (
	input  logic                clk,
	input  logic                arst_n,
	input  dfs_pkg::out_load_t  ld,
	output logic                free,
	output logic                valid,
	input  logic                stall,
	output dfs_pkg::out_word_t  word
);

	import dfs_pkg::*;

	logic      valid_q;
	out_word_t word_q;

	// register is free when empty or its word leaves this cycle
	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			word_q  <= '0;
		end else if (ld.load) begin
			valid_q <= 1'b1;
			word_q  <= ld.word;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// File: src/dfs_path_finder_top.sv
// channel  | signals                        | direction | moves
// ---------+--------------------------------+-----------+------------------------------
// cfg      | cfg_we, cfg_wdata              | in        | vertex_count register
// item     | item_valid, item_stall, item   | in        | cmd, src_vertex, dst_vertex
// result   | result_valid, result_stall,    | out       | path_vertex, path_found, last
//          | result                         |           |
//
// Clear is done in S_IDLE, add edge through S_ADD. A search passes S_PUSH per vertex
// pushed, S_STEP and S_EDGE per edge examined, S_STEP and S_POP per backtrack but the last,
// which passes S_STEP then S_NF: the walk shares one registered read port of the edge store and of the path stack.
// Emitting passes S_ORD and S_OLD per path vertex, or S_NF for not found, and waits on result_stall.
// Reset clears the list-head valid bits, so no clearing pass is needed.
// item_stall is high while an add or search is in progress.
module dfs_path_finder_top #(
	parameter int MAX_VERTICES = 32,
	parameter int MAX_EDGES    = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_wdata,
	input  logic               item_valid,
	output logic               item_stall,
	input  dfs_pkg::in_word_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output dfs_pkg::out_word_t result
);

	import dfs_pkg::*;

	localparam int VW   = $clog2(MAX_VERTICES);
	localparam int AW_E = $clog2(MAX_EDGES);
	localparam int EW   = AW_E + 1;
	localparam int DW   = $clog2(MAX_VERTICES + 1);
	localparam int SW   = VW + EW;

	localparam logic [EW-1:0]    EMPTY = EW'(MAX_EDGES);
	localparam logic [EXT_W-1:0] MAXV  = EXT_W'(MAX_VERTICES);
	localparam logic [DW-1:0]    MAXD  = DW'(MAX_VERTICES);

	typedef enum logic [3:0] {
		S_IDLE, S_ADD, S_PUSH, S_STEP, S_EDGE, S_POP, S_NF, S_ORD, S_OLD
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [VW-1:0]     v_q;
	logic [VTX_W-1:0]  tgt_q;
	logic [EW-1:0]     edges_q;
	logic [MAX_VERTICES-1:0] head_vld_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [DW-1:0]     depth_q;
	logic [EW-1:0]     cur_q;
	logic [VW-1:0]     top_q;
	logic [DW-1:0]     k_q;

	// memory ports
	logic            head_we;
	logic [VW-1:0]   head_waddr, head_raddr;
	logic [EW-1:0]   head_wdata, head_rdata;
	logic            edge_we;
	logic [AW_E-1:0] edge_waddr, edge_raddr;
	logic [SW-1:0]   edge_wdata, edge_rdata;
	logic            stk_we;
	logic [VW-1:0]   stk_waddr, stk_raddr;
	logic [SW-1:0]   stk_wdata, stk_rdata;

	logic            accept;
	logic [EXT_W-1:0] n_act;
	logic            src_ok, dst_ok, add_ok;
	logic [EW-1:0]   head_now;
	logic [VW-1:0]   e_tgt, stk_rvtx;
	logic [EW-1:0]   e_link, stk_rcur;
	logic [DW-1:0]   depth_m1, depth_m2;
	logic            tgt_new, is_last, out_free;
	out_load_t       out_ld;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;

	// active vertex count, capped at the store size
	assign n_act  = (EXT_W'(count_q) > MAXV) ? MAXV : EXT_W'(count_q);
	assign src_ok = EXT_W'(item.src_vertex) < n_act;
	assign dst_ok = EXT_W'(item.dst_vertex) < n_act;
	assign add_ok = src_ok && dst_ok && (edges_q < EMPTY);

	assign head_now = head_vld_q[v_q] ? head_rdata : EMPTY;
	assign e_tgt    = edge_rdata[SW-1 -: VW];
	assign e_link   = edge_rdata[EW-1:0];
	assign stk_rvtx = stk_rdata[SW-1 -: VW];
	assign stk_rcur = stk_rdata[EW-1:0];
	assign depth_m1 = depth_q - DW'(1);
	assign depth_m2 = depth_q - DW'(2);
	assign is_last  = (k_q + DW'(1)) == depth_q;

	// a fresh neighbour: in range, unvisited, and room on the stack
	assign tgt_new = (EXT_W'(e_tgt) < MAXV) && !visited_q[e_tgt] && (depth_q < MAXD);

	// memory addressing
	always_comb begin
		head_raddr = v_q;
		edge_raddr = cur_q[AW_E-1:0];
		stk_raddr  = k_q[VW-1:0];
		head_we    = 1'b0;
		head_waddr = v_q;
		head_wdata = edges_q;
		edge_we    = 1'b0;
		edge_waddr = edges_q[AW_E-1:0];
		edge_wdata = {VW'(tgt_q), head_now};
		stk_we     = 1'b0;
		stk_waddr  = depth_q[VW-1:0];
		stk_wdata  = {v_q, head_now};
		unique case (state_q)
			S_IDLE: head_raddr = VW'(item.src_vertex);
			S_ADD: begin
				head_we = 1'b1;
				edge_we = 1'b1;
			end
			S_PUSH: stk_we = 1'b1;
			S_STEP: stk_raddr = depth_m2[VW-1:0];
			S_EDGE: begin
				head_raddr = e_tgt;
				stk_we     = 1'b1;
				stk_waddr  = depth_m1[VW-1:0];
				stk_wdata  = {top_q, e_link};
			end
			S_POP, S_NF, S_ORD, S_OLD: begin
			end
		endcase
	end

	// result load requests
	always_comb begin
		out_ld.load             = 1'b0;
		out_ld.word.path_vertex = VTX_W'(stk_rvtx);
		out_ld.word.path_found  = 1'b1;
		out_ld.word.last        = is_last;
		if (state_q == S_NF) begin
			out_ld.load             = out_free;
			out_ld.word.path_vertex = '0;
			out_ld.word.path_found  = 1'b0;
			out_ld.word.last        = 1'b1;
		end else if (state_q == S_OLD) begin
			out_ld.load = out_free;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= CNT_RESET;
			v_q        <= '0;
			tgt_q      <= '0;
			edges_q    <= '0;
			head_vld_q <= '0;
			visited_q  <= '0;
			depth_q    <= '0;
			cur_q      <= '0;
			top_q      <= '0;
			k_q        <= '0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						v_q   <= VW'(item.src_vertex);
						tgt_q <= item.dst_vertex;
						unique case (item.cmd)
							CMD_CLEAR: begin
								head_vld_q <= '0;
								edges_q    <= '0;
							end
							CMD_ADD: begin
								if (add_ok) begin
									state_q <= S_ADD;
								end
							end
							CMD_SEARCH: begin
								visited_q <= '0;
								depth_q   <= '0;
								state_q   <= src_ok ? S_PUSH : S_NF;
							end
							default: begin
							end
						endcase
					end
				end
				S_ADD: begin
					head_vld_q[v_q] <= 1'b1;
					edges_q         <= edges_q + EW'(1);
					state_q         <= S_IDLE;
				end
				S_PUSH: begin
					visited_q[v_q] <= 1'b1;
					depth_q        <= depth_q + DW'(1);
					cur_q          <= head_now;
					top_q          <= v_q;
					k_q            <= '0;
					state_q        <= (EXT_W'(v_q) == EXT_W'(tgt_q)) ? S_ORD : S_STEP;
				end
				S_STEP: begin
					if (cur_q >= EMPTY) begin
						// list exhausted: backtrack
						depth_q <= depth_m1;
						state_q <= (depth_q == DW'(1)) ? S_NF : S_POP;
					end else begin
						state_q <= S_EDGE;
					end
				end
				S_POP: begin
					cur_q   <= stk_rcur;
					top_q   <= stk_rvtx;
					state_q <= S_STEP;
				end
				S_EDGE: begin
					cur_q   <= e_link;
					v_q     <= e_tgt;
					state_q <= tgt_new ? S_PUSH : S_STEP;
				end
				S_NF: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_ORD: state_q <= S_OLD;
				S_OLD: begin
					if (out_free) begin
						k_q     <= k_q + DW'(1);
						state_q <= is_last ? S_IDLE : S_ORD;
					end
				end
			endcase
		end
	end

	// edge store: target and link in one word
	dfs_ram #(.WIDTH(SW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (edge_wdata),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	// list heads, qualified by head_vld_q
	dfs_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	// path stack: vertex and cursor per level
	dfs_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	dfs_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (out_ld),
		.free   (out_free),
		.valid  (result_valid),
		.stall  (result_stall),
		.word   (result)
	);

endmodule
